[hw/rtl/psp_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// psp_pkg
// Shared types and constants for the program association section parser.
// ---------------------------------------------------------------------------
package psp_pkg;

    localparam int PID_W      = 13;
    localparam int PROG_W     = 16;
    localparam int CRC_W      = 32;
    localparam int COUNT_W    = 14;
    localparam int LEN_W      = 12;
    localparam int ENTRY_W    = PROG_W + 1;
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 2;
    localparam int OCC_W      = 3;

    localparam logic [LEN_W-1:0] FIXED_HDR = 12'd9;

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        RK_ENTRY  = 2'd0,
        RK_DONE   = 2'd1,
        RK_LOOKUP = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_HEADER,
        PH_ENTRIES,
        PH_CRC
    } phase_t;

    typedef struct packed {
        logic [7:0]  tid;
        logic [15:0] tsid;
        logic [4:0]  ver;
        logic        cn;
        logic [7:0]  sn;
        logic [7:0]  lsn;
    } hdr_t;

    typedef struct packed {
        logic              valid;
        result_kind_t      kind;
        logic [PID_W-1:0]  pid;
        logic [PROG_W-1:0] prog;
        logic [CRC_W-1:0]  crc;
        hdr_t              hdr;
    } psp_req_t;

    typedef struct packed {
        result_kind_t       kind;
        logic [PROG_W-1:0]  prog;
        logic [PID_W-1:0]   pid;
        logic               flag;
        hdr_t               hdr;
        logic [CRC_W-1:0]   crc;
        logic [COUNT_W-1:0] count;
    } psp_res_t;

    typedef struct packed {
        logic busy;
        logic s1_valid;
    } psp_tbl_stat_t;

endpackage
`default_nettype wire

[hw/rtl/psp_parser.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// psp_parser
// Byte-serial section parser: pointer skip, header capture, entry and CRC
// assembly. Issues one table request per entry, section end or lookup.
// ---------------------------------------------------------------------------
module psp_parser
    import psp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic             opcode,
    input  wire logic [7:0]       data_byte,
    input  wire logic             start_of_payload,
    input  wire logic [PID_W-1:0] query_pid,
    output psp_req_t              req
);

    phase_t            phase_reg, phase_next;
    logic [7:0]        skip_reg, skip_next;
    logic [2:0]        pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [31:0]       asm_reg, asm_next;
    hdr_t              hdr_reg, hdr_next;
    logic [31:0]       asm_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            skip_reg  <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            asm_reg   <= '0;
            hdr_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            asm_reg   <= asm_next;
            hdr_reg   <= hdr_next;
        end
    end

    assign asm_shift = {asm_reg[23:0], data_byte};

    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        asm_next   = asm_reg;
        hdr_next   = hdr_reg;
        req        = '0;
        req.kind   = RK_ENTRY;
        req.hdr    = hdr_reg;

        if (accept && opcode == OP_LOOKUP)
        begin
            req.valid = 1'b1;
            req.kind  = RK_LOOKUP;
            req.pid   = query_pid;
        end
        else if (accept && start_of_payload)
        begin
            skip_next  = data_byte;
            pos_next   = '0;
            asm_next   = '0;
            len_next   = '0;
            phase_next = (data_byte != 8'd0) ? PH_SKIP : PH_HEADER;
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_reg == 8'd1)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER:
                begin
                    case (pos_reg)
                        3'd0: hdr_next.tid = data_byte;
                        3'd1: len_next = {data_byte[3:0], 8'h00};
                        3'd2: len_next = len_reg | {4'h0, data_byte};
                        3'd3: hdr_next.tsid[15:8] = data_byte;
                        3'd4: hdr_next.tsid[7:0] = data_byte;
                        3'd5:
                        begin
                            hdr_next.ver = data_byte[5:1];
                            hdr_next.cn  = data_byte[0];
                        end
                        3'd6: hdr_next.sn = data_byte;
                        default: hdr_next.lsn = data_byte;
                    endcase
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg == 3'd7)
                    begin
                        len_next   = (len_reg >= FIXED_HDR) ? len_reg - FIXED_HDR : '0;
                        pos_next   = '0;
                        asm_next   = '0;
                        phase_next = (len_reg > FIXED_HDR) ? PH_ENTRIES : PH_CRC;
                    end
                end
                PH_ENTRIES:
                begin
                    asm_next = asm_shift;
                    pos_next = pos_reg + 3'd1;
                    len_next = len_reg - 12'd1;
                    if (pos_reg[1:0] == 2'd3)
                    begin
                        req.valid = 1'b1;
                        req.kind  = RK_ENTRY;
                        req.pid   = asm_shift[PID_W-1:0];
                        req.prog  = asm_shift[31:16];
                        pos_next  = '0;
                        asm_next  = '0;
                    end
                    if (len_reg == 12'd1)
                    begin
                        pos_next   = '0;
                        asm_next   = '0;
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    asm_next = asm_shift;
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg[1:0] == 2'd3)
                    begin
                        req.valid  = 1'b1;
                        req.kind   = RK_DONE;
                        req.crc    = asm_shift;
                        pos_next   = '0;
                        asm_next   = '0;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/psp_pid_table.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// psp_pid_table
// PID memory holding a known flag and first program number per PID.
// Clears after reset, then reads, updates and writes back one request a cycle.
// ---------------------------------------------------------------------------
module psp_pid_table
    import psp_pkg::*;
#(
    parameter int PID_ENTRIES = 8192
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire psp_req_t req,
    output logic         res_valid,
    output psp_res_t     res,
    output psp_tbl_stat_t stat
);

    localparam int AW = $clog2(PID_ENTRIES);

    logic [ENTRY_W-1:0] mem [PID_ENTRIES];
    logic [ENTRY_W-1:0] rd_q;

    logic               clr_reg, clr_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               s1_valid_reg;
    psp_req_t           s1_req_reg;
    logic               fwd_hit_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               known;
    logic               fresh;

    assign rd_addr = req.pid[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.valid)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            s1_valid_reg <= req.valid;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg   <= req;
        fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
        fwd_data_reg <= wr_data;
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q;
    assign known   = rd_data[ENTRY_W-1];
    assign fresh   = s1_valid_reg && (s1_req_reg.kind == RK_ENTRY) && !known;

    always_comb
    begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        count_next    = count_reg;
        wr_en         = 1'b0;
        wr_addr       = s1_req_reg.pid[AW-1:0];
        wr_data       = {1'b1, s1_req_reg.prog};

        if (clr_reg)
        begin
            wr_en         = 1'b1;
            wr_addr       = clr_addr_reg;
            wr_data       = '0;
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(PID_ENTRIES - 1))
            begin
                clr_next = 1'b0;
            end
        end
        else if (fresh)
        begin
            wr_en      = 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_valid = s1_valid_reg;
        res       = '0;
        res.kind  = s1_req_reg.kind;
        res.hdr   = s1_req_reg.hdr;
        res.count = count_next;
        case (s1_req_reg.kind)
            RK_ENTRY:
            begin
                res.prog = s1_req_reg.prog;
                res.pid  = s1_req_reg.pid;
                res.flag = !known;
            end
            RK_LOOKUP:
            begin
                res.prog = known ? rd_data[PROG_W-1:0] : '0;
                res.pid  = s1_req_reg.pid;
                res.flag = known;
            end
            RK_DONE:
            begin
                res.crc = s1_req_reg.crc;
            end
            default:
            begin
                res.flag = 1'b0;
            end
        endcase
    end

    assign stat.busy     = clr_reg;
    assign stat.s1_valid = s1_valid_reg;

endmodule
`default_nettype wire

[hw/rtl/psp_out_fifo.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// psp_out_fifo
// Small result queue that decouples the table pipeline from receiver stalls.
// ---------------------------------------------------------------------------
module psp_out_fifo
    import psp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire psp_res_t          push_data,
    input  wire logic              pop,
    output logic                   head_valid,
    output psp_res_t               head,
    output logic [FIFO_CNT_W-1:0]  count
);

    psp_res_t              q [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = q[rd_ptr_reg];
    assign count      = count_reg;

endmodule
`default_nettype wire

[hw/rtl/pat_section_parser.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pat_section_parser
// Program association section parser with a PID to program table.
// ---------------------------------------------------------------------------
// Items arrive on item_valid/item_stall: opcode 0 feeds one section byte
// (start_of_payload marks the pointer field), opcode 1 looks up query_pid.
// Results leave on result_valid/result_stall: an entry record per complete
// 4-byte entry, a section record with the CRC word, or a lookup answer.
// One item is taken per cycle while item_stall is low. Each result passes
// through the synchronous PID memory read, then the update and the result
// queue write. The PID memory update is a read-modify-write with forwarding,
// so back-to-back entries and lookups on one PID run at full rate.
// After reset the PID memory is cleared one entry per cycle, all PID_ENTRIES
// (8192 by default) entries, with item_stall high throughout.
// A three-entry result queue absorbs receiver stalls; item_stall rises when
// the results in flight reach three and falls as the receiver drains them.
// ---------------------------------------------------------------------------
module pat_section_parser
    import psp_pkg::*;
#(
    parameter int PID_ENTRIES = 8192
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic               opcode,
    input  wire logic [7:0]         data_byte,
    input  wire logic               start_of_payload,
    input  wire logic [PID_W-1:0]   query_pid,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [1:0]              result_kind,
    output logic [PROG_W-1:0]       program_number,
    output logic [PID_W-1:0]        entry_pid,
    output logic                    hit_or_new,
    output logic [7:0]              table_ident,
    output logic [15:0]             stream_ident,
    output logic [4:0]              version,
    output logic                    current_next,
    output logic [7:0]              section_index,
    output logic [7:0]              last_section_index,
    output logic [CRC_W-1:0]        section_crc,
    output logic [COUNT_W-1:0]      stored_count
);

    psp_req_t              req;
    psp_res_t              tbl_res;
    logic                  tbl_res_valid;
    psp_tbl_stat_t         tbl_stat;
    psp_res_t              head;
    logic                  head_valid;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [OCC_W-1:0]      occupancy;
    logic                  accept;
    logic                  pop;

    assign occupancy  = OCC_W'(tbl_stat.s1_valid) + OCC_W'(fifo_count);
    assign item_stall = tbl_stat.busy || (occupancy >= OCC_W'(FIFO_DEPTH));
    assign accept     = item_valid && !item_stall;
    assign pop        = head_valid && !result_stall;

    psp_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .opcode           (opcode),
        .data_byte        (data_byte),
        .start_of_payload (start_of_payload),
        .query_pid        (query_pid),
        .req              (req)
    );

    psp_pid_table #(
        .PID_ENTRIES (PID_ENTRIES)
    ) u_pid_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (tbl_res_valid),
        .res       (tbl_res),
        .stat      (tbl_stat)
    );

    psp_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (tbl_res_valid),
        .push_data  (tbl_res),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (fifo_count)
    );

    assign result_valid       = head_valid;
    assign result_kind        = head.kind;
    assign program_number     = head.prog;
    assign entry_pid          = head.pid;
    assign hit_or_new         = head.flag;
    assign table_ident        = head.hdr.tid;
    assign stream_ident       = head.hdr.tsid;
    assign version            = head.hdr.ver;
    assign current_next       = head.hdr.cn;
    assign section_index      = head.hdr.sn;
    assign last_section_index = head.hdr.lsn;
    assign section_crc        = head.crc;
    assign stored_count       = head.count;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_stat.s1_valid && fifo_count == FIFO_CNT_W'(FIFO_DEPTH) && !pop))
        else $error("result queue overflow");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(tbl_stat.busy) |-> (fifo_count == '0 && !tbl_stat.s1_valid))
        else $error("activity during memory clear");

    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == RK_DONE) |->
            (program_number == '0 && entry_pid == '0 && !hit_or_new))
        else $error("section record carries entry fields");

    a_lookup_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == RK_LOOKUP && !hit_or_new) |->
            (program_number == '0 && section_crc == '0))
        else $error("lookup miss carries a program");

endmodule
`default_nettype wire

[tb/pat_section_parser_test.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pat_section_parser_test
// Self-checking bench for the program association section parser. A short
// table of hand-built items covers the field extremes, pointer skip, restart,
// short and partial sections and lookups. Randomly built sections with random
// content, stray bytes, cut-off sections and interleaved lookups follow. Every
// accepted item runs through a local parser and PID table. Each result is
// compared field by field with the oldest waiting record. Both handshakes
// idle at random.
// ---------------------------------------------------------------------------
module pat_section_parser_test;
    import psp_pkg::*;

    localparam int TABLE_SIZE  = 8192;
    localparam int HDR_BYTES   = 8;
    localparam int ENTRY_BYTES = 4;
    localparam int ITEM_GOAL   = 800;
    localparam int HUGE_AFTER  = 600;
    localparam int HUGE_CUT    = HDR_BYTES + 16 * ENTRY_BYTES;
    localparam int QUIET_LIMIT = 50000;
    localparam int DRAIN_WAIT  = 16;

    typedef struct packed {
        logic             op;
        logic [7:0]       b;
        logic             sop;
        logic [PID_W-1:0] qpid;
        logic             typed;
        psp_res_t         want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic                opcode = OP_BYTE;
    logic [7:0]          data_byte = 8'h00;
    logic                start_of_payload = 1'b0;
    logic [PID_W-1:0]    query_pid = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [1:0]          result_kind;
    logic [PROG_W-1:0]   program_number;
    logic [PID_W-1:0]    entry_pid;
    logic                hit_or_new;
    logic [7:0]          table_ident;
    logic [15:0]         stream_ident;
    logic [4:0]          version;
    logic                current_next;
    logic [7:0]          section_index;
    logic [7:0]          last_section_index;
    logic [CRC_W-1:0]    section_crc;
    logic [COUNT_W-1:0]  stored_count;

    phase_t              ph = PH_IDLE;
    logic [LEN_W-1:0]    pos = '0;
    logic [7:0]          skip_left = '0;
    hdr_t                hdr = '0;
    logic [LEN_W-1:0]    len_left = '0;
    logic [31:0]         word = '0;
    bit                  pid_seen [TABLE_SIZE];
    logic [PROG_W-1:0]   pid_prog [TABLE_SIZE];
    logic [COUNT_W-1:0]  pid_total = '0;

    psp_res_t            awaited_records [$];
    stim_row_t           script [$];
    logic [PID_W-1:0]    pid_pool [16];
    int                  fails = 0;
    int                  fed = 0;
    int                  quiet = 0;
    int                  stall_left = 0;
    bit                  calm = 1'b0;

    pat_section_parser i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_valid         (item_valid),
        .item_stall         (item_stall),
        .opcode             (opcode),
        .data_byte          (data_byte),
        .start_of_payload   (start_of_payload),
        .query_pid          (query_pid),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .result_kind        (result_kind),
        .program_number     (program_number),
        .entry_pid          (entry_pid),
        .hit_or_new         (hit_or_new),
        .table_ident        (table_ident),
        .stream_ident       (stream_ident),
        .version            (version),
        .current_next       (current_next),
        .section_index      (section_index),
        .last_section_index (last_section_index),
        .section_crc        (section_crc),
        .stored_count       (stored_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [PID_W-1:0] pick_pid();
        if ($urandom_range(0, 1) == 0)
            return pid_pool[$urandom_range(0, 15)];
        else
            return PID_W'($urandom_range(0, TABLE_SIZE - 1));
    endfunction

    function automatic bit parse_item(input logic op, input logic [7:0] b, input logic sop,
                                      input logic [PID_W-1:0] qpid, output psp_res_t rec);
        logic [PID_W-1:0]  pid;
        logic [PROG_W-1:0] prog;
        bit                emit;
        rec = '0;
        emit = 1'b0;
        if (op == OP_LOOKUP)
        begin
            rec.kind = RK_LOOKUP;
            rec.pid = qpid;
            rec.flag = pid_seen[qpid];
            rec.prog = pid_seen[qpid] ? pid_prog[qpid] : '0;
            emit = 1'b1;
        end
        else if (sop)
        begin
            skip_left = b;
            pos = '0;
            word = '0;
            len_left = '0;
            ph = (b != 8'h00) ? PH_SKIP : PH_HEADER;
        end
        else
        begin
            case (ph)
                PH_SKIP:
                begin
                    skip_left = skip_left - 8'd1;
                    if (skip_left == 8'd0)
                        ph = PH_HEADER;
                end
                PH_HEADER:
                begin
                    case (pos)
                        12'd0: hdr.tid = b;
                        12'd1: len_left = {b[3:0], 8'h00};
                        12'd2: len_left = len_left | {4'h0, b};
                        12'd3: hdr.tsid[15:8] = b;
                        12'd4: hdr.tsid[7:0] = b;
                        12'd5:
                        begin
                            hdr.ver = b[5:1];
                            hdr.cn = b[0];
                        end
                        12'd6: hdr.sn = b;
                        default: hdr.lsn = b;
                    endcase
                    pos = pos + 12'd1;
                    if (pos >= LEN_W'(HDR_BYTES))
                    begin
                        len_left = (len_left >= FIXED_HDR) ? len_left - FIXED_HDR : '0;
                        pos = '0;
                        word = '0;
                        ph = (len_left != '0) ? PH_ENTRIES : PH_CRC;
                    end
                end
                PH_ENTRIES:
                begin
                    word = {word[23:0], b};
                    pos = pos + 12'd1;
                    len_left = len_left - 12'd1;
                    if (pos >= LEN_W'(ENTRY_BYTES))
                    begin
                        pid = word[PID_W-1:0];
                        prog = word[31:16];
                        rec.kind = RK_ENTRY;
                        rec.pid = pid;
                        rec.prog = prog;
                        if (!pid_seen[pid])
                        begin
                            pid_seen[pid] = 1'b1;
                            pid_prog[pid] = prog;
                            pid_total = pid_total + 1'b1;
                            rec.flag = 1'b1;
                        end
                        emit = 1'b1;
                        pos = '0;
                        word = '0;
                    end
                    if (len_left == '0)
                    begin
                        pos = '0;
                        word = '0;
                        ph = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    word = {word[23:0], b};
                    pos = pos + 12'd1;
                    if (pos >= LEN_W'(ENTRY_BYTES))
                    begin
                        rec.kind = RK_DONE;
                        rec.crc = word;
                        emit = 1'b1;
                        pos = '0;
                        word = '0;
                        ph = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
        rec.hdr = hdr;
        rec.count = pid_total;
        return emit;
    endfunction

    task automatic add_row(input logic op, input logic [7:0] b, input logic sop,
                           input logic [PID_W-1:0] qpid, input logic typed,
                           input psp_res_t want);
        stim_row_t row;
        row.op = op;
        row.b = b;
        row.sop = sop;
        row.qpid = qpid;
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endtask

    task automatic send_item(input logic op, input logic [7:0] b, input logic sop,
                             input logic [PID_W-1:0] qpid, input logic typed,
                             input psp_res_t want);
        int       gap;
        bit       has;
        bit       ignored;
        psp_res_t rec;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        opcode <= op;
        data_byte <= b;
        start_of_payload <= sop;
        query_pid <= qpid;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        ignored = (op == OP_BYTE) && !sop && (ph == PH_IDLE);
        has = parse_item(op, b, sop, qpid, rec);
        if (has)
            awaited_records.push_back(typed ? want : rec);
        if (!ignored)
            fed++;
    endtask

    task automatic send_lookup();
        send_item(OP_LOOKUP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_pid(),
                  1'b0, '0);
    endtask

    task automatic send_section(input bit huge);
        logic [7:0]        body [$];
        logic [LEN_W-1:0]  len;
        logic [PID_W-1:0]  pid;
        logic [PROG_W-1:0] prog;
        logic [3:0]        nib;
        logic [2:0]        resv;
        int                ptr;
        int                nbody;
        int                cut;
        int                r;
        r = $urandom_range(0, 99);
        if (huge || r < 60)
            ptr = 0;
        else if (r < 94)
            ptr = $urandom_range(1, 3);
        else if (r < 98)
            ptr = $urandom_range(4, 254);
        else
            ptr = 255;
        r = $urandom_range(0, 99);
        if (huge)
            len = '1;
        else if (r < 12)
            len = LEN_W'($urandom_range(0, 8));
        else
            len = LEN_W'(9 + ENTRY_BYTES * $urandom_range(0, 5)
                  + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0));
        repeat (ptr) body.push_back(8'($urandom_range(0, 255)));
        nib = 4'($urandom_range(0, 15));
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back({nib, len[11:8]});
        body.push_back(len[7:0]);
        repeat (5) body.push_back(8'($urandom_range(0, 255)));
        nbody = (len >= FIXED_HDR) ? int'(len - FIXED_HDR) : 0;
        while (nbody >= ENTRY_BYTES)
        begin
            pid = pick_pid();
            prog = PROG_W'($urandom_range(0, 65535));
            resv = 3'($urandom_range(0, 7));
            body.push_back(prog[15:8]);
            body.push_back(prog[7:0]);
            body.push_back({resv, pid[12:8]});
            body.push_back(pid[7:0]);
            nbody -= ENTRY_BYTES;
        end
        repeat (nbody) body.push_back(8'($urandom_range(0, 255)));
        repeat (4) body.push_back(8'($urandom_range(0, 255)));
        if (huge)
            cut = HUGE_CUT;
        else
            cut = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, body.size() - 1))
                                              : body.size();
        send_item(OP_BYTE, 8'(ptr), 1'b1, PID_W'($urandom_range(0, TABLE_SIZE - 1)),
                  1'b0, '0);
        for (int i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_lookup();
            send_item(OP_BYTE, body[i], 1'b0, PID_W'($urandom_range(0, TABLE_SIZE - 1)),
                      1'b0, '0);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (awaited_records.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        psp_res_t exp_rec;
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            if (awaited_records.size() == 0)
            begin
                $error("result_kind: expected no result, got 0x%0h", result_kind);
                fails++;
            end
            else
            begin
                exp_rec = awaited_records.pop_front();
                check_field("result_kind", 32'(exp_rec.kind), 32'(result_kind));
                check_field("program_number", 32'(exp_rec.prog), 32'(program_number));
                check_field("entry_pid", 32'(exp_rec.pid), 32'(entry_pid));
                check_field("hit_or_new", 32'(exp_rec.flag), 32'(hit_or_new));
                check_field("table_ident", 32'(exp_rec.hdr.tid), 32'(table_ident));
                check_field("stream_ident", 32'(exp_rec.hdr.tsid), 32'(stream_ident));
                check_field("version", 32'(exp_rec.hdr.ver), 32'(version));
                check_field("current_next", 32'(exp_rec.hdr.cn), 32'(current_next));
                check_field("section_index", 32'(exp_rec.hdr.sn), 32'(section_index));
                check_field("last_section_index", 32'(exp_rec.hdr.lsn),
                            32'(last_section_index));
                check_field("section_crc", exp_rec.crc, section_crc);
                check_field("stored_count", 32'(exp_rec.count), 32'(stored_count));
            end
        end
        if (stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        result_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
        if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        psp_res_t want;
        bit       huge_done;
        huge_done = 1'b0;
        for (int i = 0; i < 16; i++)
            pid_pool[i] = PID_W'($urandom_range(0, TABLE_SIZE - 1));
        pid_pool[0] = '0;
        pid_pool[1] = '1;

        want = '0;
        want.kind = RK_LOOKUP;
        add_row(OP_LOOKUP, 8'h00, 1'b0, 13'h0000, 1'b1, want);
        add_row(OP_BYTE, 8'hA5, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'h01, 1'b1, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'h47, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'hFF, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'hF0, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'h0F, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'hFF, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'hFF, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'hFF, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'hFF, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'h00, 1'b0, '0, 1'b0, '0);
        repeat (4) add_row(OP_BYTE, 8'hFF, 1'b0, '0, 1'b0, '0);
        add_row(OP_LOOKUP, 8'h00, 1'b1, 13'h1FFF, 1'b0, '0);
        add_row(OP_BYTE, 8'h12, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'h34, 1'b0, '0, 1'b0, '0);
        add_row(OP_BYTE, 8'h00, 1'b1, '0, 1'b0, '0);
        repeat (8) add_row(OP_BYTE, 8'h00, 1'b0, '0, 1'b0, '0);
        repeat (3) add_row(OP_BYTE, 8'hFF, 1'b0, '0, 1'b0, '0);
        want = '0;
        want.kind = RK_DONE;
        want.crc = '1;
        want.count = 14'd1;
        add_row(OP_BYTE, 8'hFF, 1'b0, '0, 1'b1, want);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_item(script[i].op, script[i].b, script[i].sop, script[i].qpid,
                      script[i].typed, script[i].want);
        drain_results();

        fed = 0;
        while (fed < ITEM_GOAL)
        begin
            calm = ($urandom_range(0, 7) == 0);
            if (!huge_done && fed >= HUGE_AFTER)
            begin
                send_section(1'b1);
                huge_done = 1'b1;
            end
            else
                send_section(1'b0);
            if ($urandom_range(0, 3) == 0)
                send_lookup();
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3))
                    send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0,
                              PID_W'($urandom_range(0, TABLE_SIZE - 1)), 1'b0, '0);
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end
        calm = 1'b0;

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

[pat_section_parser.f]
hw/rtl/psp_pkg.sv
hw/rtl/psp_parser.sv
hw/rtl/psp_pid_table.sv
hw/rtl/psp_out_fifo.sv
hw/rtl/pat_section_parser.sv
tb/pat_section_parser_test.sv
